### hdl/rrle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rrle_pkg;

    localparam int RING_DEPTH_DEF = 128;
    localparam int MIN_RUN_DEF    = 3;
    localparam int BYTE_W         = 8;
    localparam int CNT_W          = 7;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_START,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_DECIDE,
        ST_HDR,
        ST_REP_BYTE,
        ST_LIT_RD,
        ST_LIT_EMIT,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic              byte_valid;
        logic [BYTE_W-1:0] data;
        logic              done;
    } t_pack_ctl;

    typedef struct packed {
        logic byte_ready;
        logic done_ready;
    } t_pack_sts;

endpackage

`default_nettype wire

### hdl/rrle_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rrle_in_if;
    import rrle_pkg::*;

    logic              valid;
    logic              ready;
    logic              opcode;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output opcode, output data_byte, input ready);
    modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

`default_nettype wire

### hdl/rrle_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rrle_out_if;
    import rrle_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] first_byte;
    logic [BYTE_W-1:0] second_byte;
    logic              second_valid;
    logic              last;

    modport source (output valid, output first_byte, output second_byte,
                    output second_valid, output last, input ready);
    modport sink   (input valid, input first_byte, input second_byte,
                    input second_valid, input last, output ready);
endinterface

`default_nettype wire

### hdl/ring_rle_byte_encoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Fields                                         Handshake
// i_in      in   opcode[0], data_byte[7:0]                      valid/ready
// o_out     out  first_byte[7:0], second_byte[7:0],             valid/ready
//                second_valid, last
//
// Each item walks the pending bytes through the ring's registered read port:
// scan start, then a read state and a compare state per byte scanned, then
// decide. Each emitted block adds a header, then the repeat byte or a read and
// an emit state per literal byte, and the scan starts again. An empty ring goes
// from scan start straight to finish.
// i_in.ready is high only between items.
// Synchronous reset empties the ring pointers; ring contents need no clearing.
// A stalled o_out holds the sequencer at the next byte or at the end of the item;
// one finished word waits in the output register while the next item is taken.

module ring_rle_byte_encoder
    import rrle_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    parameter int MIN_RUN    = MIN_RUN_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rrle_in_if.sink    i_in,
    rrle_out_if.source o_out
);

    localparam int PTR_W                 = $clog2(RING_DEPTH);
    localparam logic [PTR_W:0] DEPTH_X   = (PTR_W+1)'(RING_DEPTH);
    localparam logic [PTR_W-1:0] LAST_IX = PTR_W'(RING_DEPTH - 1);
    localparam logic [PTR_W-1:0] MAX_BLK = PTR_W'(RING_DEPTH - 1);
    localparam logic [PTR_W-1:0] RUN_MIN = PTR_W'(MIN_RUN);

    function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] p);
        ring_inc = (p == LAST_IX) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] p,
                                                  input logic [PTR_W-1:0] n);
        logic [PTR_W:0] s;
        s = {1'b0, p} + {1'b0, n};
        ring_add = (s >= DEPTH_X) ? PTR_W'(s - DEPTH_X) : s[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ring_dist(input logic [PTR_W-1:0] from,
                                                   input logic [PTR_W-1:0] to);
        ring_dist = (to >= from) ? to - from
                                 : PTR_W'({1'b0, to} + DEPTH_X - {1'b0, from});
    endfunction

    t_state            r_state, n_state;
    logic [PTR_W-1:0]  r_head, n_head;
    logic [PTR_W-1:0]  r_tail, n_tail;
    logic [PTR_W-1:0]  r_idx, n_idx;
    logic [PTR_W-1:0]  r_pos, n_pos;
    logic [PTR_W-1:0]  r_len, n_len;
    logic [PTR_W-1:0]  r_pend, n_pend;
    logic [PTR_W-1:0]  r_cnt, n_cnt;
    logic              r_rep, n_rep;
    logic              r_flush, n_flush;
    logic [BYTE_W-1:0] r_prev, n_prev;
    logic              r_prev_valid, n_prev_valid;

    logic              wr_en;
    logic [PTR_W-1:0]  rd_addr;
    logic [BYTE_W-1:0] rd_data;
    t_pack_ctl         w_ctl;
    t_pack_sts         w_sts;

    logic              run;
    logic              rep;
    logic [PTR_W-1:0]  cnt;

    rrle_ring #(
        .RING_DEPTH(RING_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_head),
        .i_wr_data (i_in.data_byte),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    rrle_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_sts   (w_sts),
        .o_out   (o_out)
    );

    assign i_in.ready = (r_state == ST_IDLE);
    assign rd_addr    = (r_state == ST_SCAN_RD) ? r_idx : r_tail;

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_len        = r_len;
        n_pend       = r_pend;
        n_cnt        = r_cnt;
        n_rep        = r_rep;
        n_flush      = r_flush;
        n_prev       = r_prev;
        n_prev_valid = r_prev_valid;
        wr_en        = 1'b0;

        run = (r_len >= RUN_MIN);
        rep = run && (r_pos == r_len);
        cnt = run ? (rep ? r_len : r_pos - r_len) : r_pend;

        w_ctl.byte_valid = r_state inside {ST_HDR, ST_REP_BYTE, ST_LIT_EMIT};
        w_ctl.done       = (r_state == ST_FINISH);
        case (r_state)
            ST_HDR:      w_ctl.data = {r_rep, CNT_W'(r_cnt)};
            ST_REP_BYTE: w_ctl.data = r_prev;
            default:     w_ctl.data = rd_data;
        endcase

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_flush = (i_in.opcode == OP_FLUSH);
                    if (i_in.opcode == OP_PUSH && ring_inc(r_head) != r_tail) begin
                        wr_en  = 1'b1;
                        n_head = ring_inc(r_head);
                    end
                    n_state = ST_SCAN_START;
                end
            end
            ST_SCAN_START: begin
                n_pend       = ring_dist(r_tail, r_head);
                n_idx        = r_tail;
                n_pos        = '0;
                n_len        = PTR_W'(1);
                n_prev_valid = 1'b0;
                n_state      = (r_head == r_tail) ? ST_FINISH : ST_SCAN_RD;
            end
            ST_SCAN_RD: begin
                n_state = ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                if (r_prev_valid && rd_data == r_prev) begin
                    n_len = r_len + 1'b1;
                end else begin
                    n_len = PTR_W'(1);
                end
                if (!(r_prev_valid && rd_data == r_prev) && run) begin
                    n_len   = r_len;
                    n_state = ST_DECIDE;
                end else begin
                    n_prev       = rd_data;
                    n_prev_valid = 1'b1;
                    n_idx        = ring_inc(r_idx);
                    n_pos        = r_pos + 1'b1;
                    n_state      = (r_pos + 1'b1 == r_pend) ? ST_DECIDE : ST_SCAN_RD;
                end
            end
            ST_DECIDE: begin
                n_cnt = cnt;
                n_rep = rep;
                if (cnt == '0 || (cnt == r_pend && cnt < MAX_BLK && !r_flush)) begin
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_HDR;
                end
            end
            ST_HDR: begin
                if (w_sts.byte_ready) begin
                    n_state = r_rep ? ST_REP_BYTE : ST_LIT_RD;
                end
            end
            ST_REP_BYTE: begin
                if (w_sts.byte_ready) begin
                    n_tail  = ring_add(r_tail, r_cnt);
                    n_state = ST_SCAN_START;
                end
            end
            ST_LIT_RD: begin
                n_state = ST_LIT_EMIT;
            end
            ST_LIT_EMIT: begin
                if (w_sts.byte_ready) begin
                    n_tail  = ring_inc(r_tail);
                    n_cnt   = r_cnt - 1'b1;
                    n_state = (r_cnt == PTR_W'(1)) ? ST_SCAN_START : ST_LIT_RD;
                end
            end
            ST_FINISH: begin
                if (w_sts.done_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_pos        <= n_pos;
        r_len        <= n_len;
        r_pend       <= n_pend;
        r_cnt        <= n_cnt;
        r_rep        <= n_rep;
        r_flush      <= n_flush;
        r_prev       <= n_prev;
        r_prev_valid <= n_prev_valid;
    end

    a_head_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |=> (r_head == $past(r_head)))
        else $error("head moved while an item was in progress");

    a_block_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HDR) |-> (r_cnt != '0 && r_cnt <= r_pend))
        else $error("block count outside pending bytes");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN_CMP) |-> (r_pos < r_pend))
        else $error("scan ran past the head");

    a_lit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LIT_EMIT) |-> (r_cnt != '0))
        else $error("literal byte emitted with no count left");

endmodule

`default_nettype wire

### hdl/rrle_ring.sv
`timescale 1ns / 1ps
`default_nettype none

module rrle_ring
    import rrle_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    localparam int PTR_W = $clog2(RING_DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [PTR_W-1:0]  i_wr_addr,
    input  wire logic [BYTE_W-1:0] i_wr_data,
    input  wire logic [PTR_W-1:0]  i_rd_addr,
    output logic      [BYTE_W-1:0] o_rd_data
);

    logic [BYTE_W-1:0] r_mem [RING_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

### hdl/rrle_pack.sv
`timescale 1ns / 1ps
`default_nettype none

module rrle_pack
    import rrle_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_pack_ctl i_ctl,
    output t_pack_sts      o_sts,
    rrle_out_if.source     o_out
);

    logic              r_stg_valid, n_stg_valid;
    logic              r_stg_full, n_stg_full;
    logic [BYTE_W-1:0] r_stg_first, n_stg_first;
    logic [BYTE_W-1:0] r_stg_second, n_stg_second;

    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_out_first, n_out_first;
    logic [BYTE_W-1:0] r_out_second, n_out_second;
    logic              r_out_sv, n_out_sv;
    logic              r_out_last, n_out_last;

    logic out_free;
    logic byte_take;
    logic done_take;
    logic push_out;

    always_comb begin
        out_free         = !r_out_valid || o_out.ready;
        o_sts.byte_ready = !r_stg_full || out_free;
        o_sts.done_ready = !r_stg_valid || out_free;
        byte_take        = i_ctl.byte_valid && o_sts.byte_ready;
        done_take        = i_ctl.done && o_sts.done_ready;
        push_out         = (byte_take && r_stg_full) || (done_take && r_stg_valid);

        n_out_valid  = r_out_valid;
        n_out_first  = r_out_first;
        n_out_second = r_out_second;
        n_out_sv     = r_out_sv;
        n_out_last   = r_out_last;
        if (push_out) begin
            n_out_valid  = 1'b1;
            n_out_first  = r_stg_first;
            n_out_second = r_stg_second;
            n_out_sv     = r_stg_full;
            n_out_last   = done_take;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        n_stg_valid  = r_stg_valid;
        n_stg_full   = r_stg_full;
        n_stg_first  = r_stg_first;
        n_stg_second = r_stg_second;
        if (byte_take) begin
            if (!r_stg_valid || r_stg_full) begin
                n_stg_valid  = 1'b1;
                n_stg_full   = 1'b0;
                n_stg_first  = i_ctl.data;
                n_stg_second = '0;
            end else begin
                n_stg_full   = 1'b1;
                n_stg_second = i_ctl.data;
            end
        end else if (done_take) begin
            n_stg_valid = 1'b0;
            n_stg_full  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid <= 1'b0;
            r_stg_full  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_stg_valid <= n_stg_valid;
            r_stg_full  <= n_stg_full;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stg_first  <= n_stg_first;
        r_stg_second <= n_stg_second;
        r_out_first  <= n_out_first;
        r_out_second <= n_out_second;
        r_out_sv     <= n_out_sv;
        r_out_last   <= n_out_last;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.first_byte   = r_out_first;
    assign o_out.second_byte  = r_out_second;
    assign o_out.second_valid = r_out_sv;
    assign o_out.last         = r_out_last;

    a_full_has_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stg_full |-> r_stg_valid)
        else $error("staged pair full without a first byte");

    a_single_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_sv) |-> (r_out_second == '0))
        else $error("unpaired word carries a nonzero second byte");

    a_no_word_and_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctl.byte_valid && i_ctl.done))
        else $error("byte and end of item offered together");

endmodule

`default_nettype wire

### tb/tb_ring_rle_byte_encoder.sv
`timescale 1ns / 1ps

module tb_ring_rle_byte_encoder;
    import rrle_pkg::*;

    localparam int MAX_BLOCK    = RING_DEPTH_DEF - 1;
    localparam int MAX_BYTES    = RING_DEPTH_DEF;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 2 * RING_DEPTH_DEF + 40;
    localparam int MIX_ITEMS    = 90;
    localparam int IDLE_PCT     = 24;

    localparam logic [BYTE_W-1:0] REP_FLAG = 8'h80;

    typedef struct packed {
        logic [BYTE_W-1:0] first_byte;
        logic [BYTE_W-1:0] second_byte;
        logic              second_valid;
        logic              last;
    } t_word;

    typedef struct packed {
        logic              op;
        logic [BYTE_W-1:0] data;
        logic [7:0]        reps;
        logic [BYTE_W-1:0] step;
        logic              typed;
        logic [1:0]        exp_n;
        t_word             exp0;
        t_word             exp1;
    } t_row;

    localparam t_word NO_WORD = '0;
    localparam int    DIR_ROWS = 16;

    localparam t_row DIR_TAB [DIR_ROWS] = '{
        '{OP_FLUSH, 8'h00, 8'd1, 8'h00, 1'b1, 2'd0, NO_WORD, NO_WORD},
        '{OP_PUSH,  8'h00, 8'd3, 8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{OP_FLUSH, 8'hff, 8'd1, 8'h00, 1'b1, 2'd1,
          '{8'h83, 8'h00, 1'b1, 1'b1}, NO_WORD},
        '{OP_PUSH,  8'hff, 8'd3, 8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{OP_FLUSH, 8'h00, 8'd1, 8'h00, 1'b1, 2'd1,
          '{8'h83, 8'hff, 1'b1, 1'b1}, NO_WORD},
        '{OP_PUSH,  8'h5a, 8'd1, 8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{OP_FLUSH, 8'ha5, 8'd1, 8'h00, 1'b1, 2'd1,
          '{8'h01, 8'h5a, 1'b1, 1'b1}, NO_WORD},
        '{OP_PUSH,  8'h12, 8'd2, 8'h22, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{OP_FLUSH, 8'h00, 8'd1, 8'h00, 1'b1, 2'd2,
          '{8'h02, 8'h12, 1'b1, 1'b0}, '{8'h34, 8'h00, 1'b0, 1'b1}},
        '{OP_PUSH,  8'h77, 8'd2, 8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{OP_PUSH,  8'h09, 8'd3, 8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{OP_PUSH,  8'h03, 8'd1, 8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{OP_FLUSH, 8'h00, 8'd1, 8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{OP_PUSH,  8'h3c, 8'd4, 8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{OP_PUSH,  8'hc3, 8'd1, 8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{OP_FLUSH, 8'h7e, 8'd1, 8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    rrle_in_if  in_ch ();
    rrle_out_if out_ch ();

    ring_rle_byte_encoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    logic [BYTE_W-1:0] ring_mem [RING_DEPTH_DEF];
    logic [CNT_W-1:0]  head_ptr;
    logic [CNT_W-1:0]  tail_ptr;
    logic [BYTE_W-1:0] enc_bytes [$];
    t_word             code_words_q [$];

    int in_idle_pct  = IDLE_PCT;
    int out_idle_pct = IDLE_PCT;
    int hold_left    = 0;
    int err_cnt      = 0;
    int n_push       = 0;
    int n_flush      = 0;
    int n_words      = 0;
    int rep_blocks   = 0;
    int lit_blocks   = 0;
    int longest_blk  = 0;

    always #10 i_clk = ~i_clk;

    function automatic void put_code_byte(input logic [BYTE_W-1:0] b);
        if (enc_bytes.size() < MAX_BYTES) begin
            enc_bytes.push_back(b);
        end
    endfunction

    function automatic void encode_item(input logic op, input logic [BYTE_W-1:0] data);
        logic [CNT_W-1:0] idx;
        logic [CNT_W-1:0] nt;
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] pend;
        logic [8:0]       prev;
        int               len;
        logic             rep;
        enc_bytes.delete();
        if (op == OP_PUSH && CNT_W'(head_ptr + 1'b1) != tail_ptr) begin
            ring_mem[head_ptr] = data;
            head_ptr = head_ptr + 1'b1;
        end
        while (head_ptr != tail_ptr) begin
            pend = head_ptr - tail_ptr;
            prev = 9'h100;
            idx  = tail_ptr;
            len  = 1;
            // find the first run of MIN_RUN or more equal bytes
            do begin
                if ({1'b0, ring_mem[idx]} == prev) begin
                    len++;
                end else begin
                    if (len >= MIN_RUN_DEF) break;
                    len = 1;
                end
                prev = {1'b0, ring_mem[idx]};
                idx  = idx + 1'b1;
            end while (idx != head_ptr);
            rep = 1'b0;
            if (len >= MIN_RUN_DEF) begin
                nt = idx - CNT_W'(len);
                if (nt == tail_ptr) begin
                    rep = 1'b1;
                    nt  = idx;
                end
            end else begin
                nt = head_ptr;
            end
            cnt = nt - tail_ptr;
            if (cnt == 0) break;
            // hold a block that takes every pending byte unless flushing or at MAX_BLOCK
            if (cnt == pend && cnt < MAX_BLOCK && op != OP_FLUSH) break;
            if (int'(cnt) > longest_blk) longest_blk = cnt;
            if (rep) begin
                rep_blocks++;
                put_code_byte(REP_FLAG | {1'b0, cnt});
                put_code_byte(prev[BYTE_W-1:0]);
                tail_ptr = tail_ptr + cnt;
            end else begin
                lit_blocks++;
                put_code_byte({1'b0, cnt});
                repeat (cnt) begin
                    put_code_byte(ring_mem[tail_ptr]);
                    tail_ptr = tail_ptr + 1'b1;
                end
            end
        end
    endfunction

    task automatic send_word(input t_row item);
        int    n;
        t_word w;
        while ($urandom_range(99) < in_idle_pct) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid     <= 1'b1;
        in_ch.opcode    <= item.op;
        in_ch.data_byte <= item.data;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        encode_item(item.op, item.data);
        if (item.op == OP_FLUSH) n_flush++;
        else n_push++;
        if (item.typed) begin
            if (item.exp_n > 0) code_words_q.push_back(item.exp0);
            if (item.exp_n > 1) code_words_q.push_back(item.exp1);
        end else begin
            n = (enc_bytes.size() + 1) / 2;
            for (int k = 0; k < n; k++) begin
                w.first_byte = enc_bytes[2*k];
                if (2*k + 1 < enc_bytes.size()) begin
                    w.second_byte  = enc_bytes[2*k+1];
                    w.second_valid = 1'b1;
                end else begin
                    w.second_byte  = '0;
                    w.second_valid = 1'b0;
                end
                w.last = (k == n - 1);
                code_words_q.push_back(w);
            end
        end
    endtask

    task automatic send_byte(input logic op, input logic [BYTE_W-1:0] data);
        t_row r;
        r      = '0;
        r.op   = op;
        r.data = data;
        send_word(r);
    endtask

    always @(posedge i_clk) begin : out_check
        t_word got;
        t_word want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = {out_ch.first_byte, out_ch.second_byte, out_ch.second_valid, out_ch.last};
            n_words++;
            if (code_words_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10) begin
                    $display("%0t: unexpected word first=%h second=%h sv=%b last=%b",
                             $realtime, got.first_byte, got.second_byte,
                             got.second_valid, got.last);
                end
            end else begin
                want = code_words_q.pop_front();
                if (got !== want) begin
                    err_cnt++;
                    if (err_cnt <= 10) begin
                        $display("%0t: word %0d exp first=%h second=%h sv=%b last=%b",
                                 $realtime, n_words, want.first_byte, want.second_byte,
                                 want.second_valid, want.last);
                        $display("%0t: word %0d got first=%h second=%h sv=%b last=%b",
                                 $realtime, n_words, got.first_byte, got.second_byte,
                                 got.second_valid, got.last);
                    end
                end
            end
        end
    end

    initial begin : out_sink
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
            end
        end
    end

    initial begin : watchdog
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stim
        t_row              r;
        int                len;
        int                pick;
        int                mix_items;
        bit                press_done;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] b_alt;
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.opcode    = OP_PUSH;
        in_ch.data_byte = '0;
        head_ptr        = '0;
        tail_ptr        = '0;
        press_done      = 1'b0;
        mix_items       = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int row = 0; row < DIR_ROWS; row++) begin
            for (int i = 0; i < int'(DIR_TAB[row].reps); i++) begin
                r      = DIR_TAB[row];
                r.data = DIR_TAB[row].data + BYTE_W'(i) * DIR_TAB[row].step;
                send_word(r);
            end
        end

        while (mix_items < MIX_ITEMS) begin
            if (mix_items >= 60 && mix_items < 95) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end else begin
                in_idle_pct  = IDLE_PCT;
                out_idle_pct = IDLE_PCT;
            end
            // stall the output while flushed literals fill the word path
            if (mix_items >= 40 && !press_done) begin
                hold_left = HOLD_CYCLES;
                send_byte(OP_FLUSH, '0);
                b = $urandom;
                for (int i = 0; i < 6; i++) send_byte(OP_PUSH, b + BYTE_W'(i));
                send_byte(OP_FLUSH, '0);
                mix_items += 8;
                press_done = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 12) begin
                send_byte(OP_FLUSH, BYTE_W'($urandom));
                mix_items++;
            end else if (pick < 45) begin
                b   = $urandom;
                len = $urandom_range(1, 10);
                repeat (len) send_byte(OP_PUSH, b);
                mix_items += len;
            end else if (pick < 62) begin
                b     = $urandom;
                b_alt = b ^ BYTE_W'($urandom_range(1, 255));
                len   = $urandom_range(2, 8);
                for (int i = 0; i < len; i++) send_byte(OP_PUSH, ((i / 2) % 2) ? b_alt : b);
                mix_items += len;
            end else begin
                len = $urandom_range(1, 10);
                repeat (len) send_byte(OP_PUSH, BYTE_W'($urandom));
                mix_items += len;
            end
        end

        @(negedge i_clk);
        in_ch.valid  <= 1'b0;
        out_idle_pct = 0;
        while (code_words_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d pushes and %0d flushes, checked %0d encoded words",
                 n_push, n_flush, n_words);
        $display("Blocks: %0d repeat, %0d literal, longest %0d bytes",
                 rep_blocks, lit_blocks, longest_blk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
